// File: rtl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// types and constants shared by the contiguous page allocator modules
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

   // request kinds
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   // configuration register indexes
   localparam logic CSR_POOL_BASE    = 1'b0;
   localparam logic CSR_PAGES_IN_USE = 1'b1;

   // page mark bits
   typedef logic [1:0] marks_type;
   localparam marks_type MARK_NONE  = 2'b00;
   localparam marks_type MARK_TAKEN = 2'b01;
   localparam marks_type MARK_LAST  = 2'b10;

   typedef struct packed {
      logic        op;
      logic [10:0] page_count;
      logic [31:0] block_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] granted_address;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_MARK,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_INC,
      IDX_ADDR,
      IDX_START
   } idx_op_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      idx_op_type idx_op;
      logic       run_clr;
      logic       run_step;
      logic       found_load;
      logic       wr_en;
      marks_type  wr_mark;
      logic       res_set;
      logic [1:0] res_code;
      logic       res_grant;
      logic       rsp_push;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_free;
      logic bad_count;
      logic bad_addr;
      logic scan_end;
      logic found;
      logic taken;
      logic last;
      logic mark_last;
      logic clr_last;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/cpa_ram.sv
// ----------------------------------------------------------------------------
// cpa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/cpa_ctrl.sv
// ----------------------------------------------------------------------------
// cpa_ctrl
// sequencer for the clearing pass, first-fit scan, marking and free walk
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   output      cpa_pkg::cmd_type  cmd,
   input  wire cpa_pkg::stat_type stat
);

   cpa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpa_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpa_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = cpa_pkg::ST_IDLE;
         end
         cpa_pkg::ST_IDLE: begin
            if (req_valid) state_in = cpa_pkg::ST_CHECK;
         end
         cpa_pkg::ST_CHECK: begin
            if (stat.op_free) begin
               state_in = stat.bad_addr ? cpa_pkg::ST_DONE : cpa_pkg::ST_WALK;
            end else begin
               state_in = stat.bad_count ? cpa_pkg::ST_DONE : cpa_pkg::ST_SCAN;
            end
         end
         cpa_pkg::ST_SCAN: begin
            if (stat.scan_end) state_in = cpa_pkg::ST_DONE;
            else if (stat.found) state_in = cpa_pkg::ST_MARK;
         end
         cpa_pkg::ST_MARK: begin
            if (stat.mark_last) state_in = cpa_pkg::ST_DONE;
         end
         cpa_pkg::ST_WALK: begin
            if (stat.scan_end || !stat.taken || stat.last) state_in = cpa_pkg::ST_DONE;
         end
         cpa_pkg::ST_DONE: begin
            if (stat.rsp_free) state_in = cpa_pkg::ST_IDLE;
         end
         default: state_in = cpa_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.idx_op     = cpa_pkg::IDX_HOLD;
      cmd.wr_mark    = cpa_pkg::MARK_NONE;
      cmd.res_code   = cpa_pkg::STATUS_OK;
      unique case (state_ff)
         cpa_pkg::ST_CLEAR: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = stat.clr_last ? cpa_pkg::IDX_ZERO : cpa_pkg::IDX_INC;
         end
         cpa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         cpa_pkg::ST_CHECK: begin
            if (stat.op_free) begin
               if (stat.bad_addr) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = cpa_pkg::STATUS_IGNORED;
               end else begin
                  cmd.idx_op = cpa_pkg::IDX_ADDR;
               end
            end else begin
               if (stat.bad_count) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = cpa_pkg::STATUS_NO_ROOM;
               end else begin
                  cmd.idx_op  = cpa_pkg::IDX_ZERO;
                  cmd.run_clr = 1'b1;
               end
            end
         end
         cpa_pkg::ST_SCAN: begin
            if (stat.scan_end) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = cpa_pkg::STATUS_NO_ROOM;
            end else if (stat.found) begin
               cmd.found_load = 1'b1;
               cmd.idx_op     = cpa_pkg::IDX_START;
            end else begin
               cmd.idx_op   = cpa_pkg::IDX_INC;
               cmd.run_step = 1'b1;
            end
         end
         cpa_pkg::ST_MARK: begin
            cmd.wr_en = 1'b1;
            if (stat.mark_last) begin
               cmd.wr_mark   = cpa_pkg::MARK_TAKEN | cpa_pkg::MARK_LAST;
               cmd.res_set   = 1'b1;
               cmd.res_grant = 1'b1;
            end else begin
               cmd.wr_mark = cpa_pkg::MARK_TAKEN;
               cmd.idx_op  = cpa_pkg::IDX_INC;
            end
         end
         cpa_pkg::ST_WALK: begin
            if (stat.scan_end || !stat.taken) begin
               cmd.res_set = 1'b1;
            end else begin
               cmd.wr_en = 1'b1;
               if (stat.last) cmd.res_set = 1'b1;
               else cmd.idx_op = cpa_pkg::IDX_INC;
            end
         end
         cpa_pkg::ST_DONE: begin
            cmd.rsp_push = stat.rsp_free;
         end
         default: begin
            cmd.idx_op = cpa_pkg::IDX_HOLD;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/cpa_dp.sv
// ----------------------------------------------------------------------------
// cpa_dp
// page mark store, index and run counters, range checks and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_dp #(
   parameter int MAX_PAGES  = 1024,
   parameter int PAGE_SHIFT = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cpa_pkg::req_type req_data,
   input  wire logic             csr_valid,
   input  wire logic             csr_index,
   input  wire logic [31:0]      csr_data,
   input  wire logic             rsp_ready,
   output      logic             rsp_valid,
   output      cpa_pkg::rsp_type rsp_data,
   input  wire cpa_pkg::cmd_type cmd,
   output      cpa_pkg::stat_type stat
);

   localparam int AW = $clog2(MAX_PAGES);
   localparam int NW = $clog2(MAX_PAGES + 1);
   localparam int CW = (NW > 11) ? NW : 11;
   localparam int SW = NW + PAGE_SHIFT;
   localparam int EW = ((SW > 32) ? SW : 32) + 1;

   // configuration
   logic [31:0] pool_base_ff;
   logic [10:0] pages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
         pages_ff     <= '0;
      end else if (csr_valid) begin
         if (csr_index == cpa_pkg::CSR_POOL_BASE) pool_base_ff <= csr_data;
         else pages_ff <= csr_data[10:0];
      end
   end

   // request capture
   logic          op_ff;
   logic [10:0]   count_ff;
   logic [31:0]   addr_ff;
   logic [NW-1:0] n_ff, n_in;

   assign n_in = (CW'(pages_ff) > CW'(MAX_PAGES)) ? NW'(MAX_PAGES) : NW'(pages_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.op;
         count_ff <= req_data.page_count;
         addr_ff  <= req_data.block_address;
         n_ff     <= n_in;
      end
   end

   // free range check
   logic [31:0]   offset;
   logic [NW-1:0] addr_idx;
   logic [EW-1:0] end_addr;

   assign offset   = addr_ff - pool_base_ff;
   assign addr_idx = NW'(offset >> PAGE_SHIFT);
   assign end_addr = EW'(pool_base_ff) + (EW'(n_ff) << PAGE_SHIFT);

   // page index, run length, found run
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] run_ff, run_in;
   logic [NW-1:0] start_ff, start_in;
   logic [NW-1:0] end_ff;
   cpa_pkg::marks_type rd_mark;
   logic          taken;

   assign taken    = (rd_mark & cpa_pkg::MARK_TAKEN) != cpa_pkg::MARK_NONE;
   assign start_in = idx_ff + NW'(1) - NW'(count_ff);

   always_comb begin
      idx_in = idx_ff;
      case (cmd.idx_op)
         cpa_pkg::IDX_ZERO:  idx_in = '0;
         cpa_pkg::IDX_INC:   idx_in = idx_ff + NW'(1);
         cpa_pkg::IDX_ADDR:  idx_in = addr_idx;
         cpa_pkg::IDX_START: idx_in = start_in;
         default:            idx_in = idx_ff;
      endcase
   end

   always_comb begin
      run_in = run_ff;
      if (cmd.run_clr) run_in = '0;
      else if (cmd.run_step) run_in = taken ? '0 : run_ff + NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (cmd.found_load) begin
         start_ff <= start_in;
         end_ff   <= idx_ff;
      end
   end

   // read address follows the next index so data lines up with idx_ff
   cpa_ram #(
      .WIDTH ($bits(cpa_pkg::marks_type)),
      .DEPTH (MAX_PAGES)
   ) u_marks (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (cmd.wr_mark),
      .rd_addr (idx_in[AW-1:0]),
      .rd_data (rd_mark)
   );

   // result and output register
   logic [1:0]       res_code_ff;
   logic [31:0]      res_addr_ff;
   logic [31:0]      grant_addr;
   logic             rsp_valid_ff, rsp_valid_in;
   cpa_pkg::rsp_type rsp_data_ff;

   assign grant_addr = pool_base_ff + 32'(SW'(start_ff) << PAGE_SHIFT);

   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_code_ff <= cmd.res_code;
         res_addr_ff <= cmd.res_grant ? grant_addr : '0;
      end
      if (cmd.rsp_push) begin
         rsp_data_ff.status          <= res_code_ff;
         rsp_data_ff.granted_address <= res_addr_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_push) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status to the controller
   always_comb begin
      stat.op_free   = op_ff == cpa_pkg::OP_FREE;
      stat.bad_count = (count_ff == '0) || (CW'(count_ff) > CW'(n_ff));
      stat.bad_addr  = (addr_ff == '0) || (addr_ff < pool_base_ff) ||
                       (EW'(addr_ff) >= end_addr);
      stat.scan_end  = idx_ff >= n_ff;
      stat.found     = !taken && (CW'(run_ff) + CW'(1) == CW'(count_ff));
      stat.taken     = taken;
      stat.last      = (rd_mark & cpa_pkg::MARK_LAST) != cpa_pkg::MARK_NONE;
      stat.mark_last = idx_ff == end_ff;
      stat.clr_last  = idx_ff == NW'(MAX_PAGES - 1);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

// File: rtl/contiguous_page_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// first-fit allocator of runs of contiguous pages
// ----------------------------------------------------------------------------
// Every page of the pool holds a taken mark and a last-of-block mark in a
// MAX_PAGES entry ram that is read and written one page per cycle. After
// reset the block runs a clearing pass, with req_ready low, that frees every
// page; csr writes are taken at any time. An allocate transaction scans the
// pages from index 0 one per cycle until it finds the first run of
// page_count free pages or reaches the pool end, and writes a found run one
// page per cycle; a count of 0 or above the pool is answered without a scan.
// A free transaction walks from the addressed page one page per cycle until
// it clears a last page, meets a free page or reaches the pool end; an
// ignored address is answered without a walk. One transaction is in work at
// a time; the finished response sits in an output register, so the next
// request is taken while the response waits for rsp_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_page_allocator #(
   parameter int MAX_PAGES  = 1024,
   parameter int PAGE_SHIFT = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire cpa_pkg::req_type req_data,
   // response channel
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      cpa_pkg::rsp_type rsp_data,
   // configuration write channel
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic             csr_index,
   input  wire logic [31:0]      csr_data
);

   cpa_pkg::cmd_type  cmd;
   cpa_pkg::stat_type stat;

   // registers are plain flops, always writable
   assign csr_ready = 1'b1;

   // sequencer: clearing pass, scan, mark, walk, response hand-off
   cpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // mark store, counters, range checks, output register
   cpa_dp #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire

// File: rtl/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_checker
// port level checks of the contiguous page allocator
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire cpa_pkg::rsp_type rsp_data,
   input wire logic             csr_valid,
   input wire logic             csr_ready
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a failed transaction carries address zero
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != cpa_pkg::STATUS_OK |->
      rsp_data.granted_address == 32'd0)
      else $error("address on a failed transaction");

   // one transaction in work at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // clearing pass follows reset
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   // register writes never stall
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the first-fit contiguous page allocator
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the page marks and both pool registers.
// It works out the response of every request when the request is accepted
// and grades the responses in order. A short directed run covers the corner
// cases of the pool. Randomized phases follow, each with its own pool
// setting. Most frees in those phases target blocks that were granted
// earlier. Both channels idle at random, and each new pool setting is
// written only once every response has come back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   import cpa_pkg::*;

   localparam int MAX_PAGES    = 1024;
   localparam int PAGE_SHIFT   = 12;
   localparam int RANDOM_ITEMS = 360;
   // a full scan of the largest pool plus stalls fits many times over
   localparam int QUIET_LIMIT  = 20000;

   // mirror of the allocator: page marks, registers, responses still owed
   class page_pool_scoreboard;
      marks_type   marks [MAX_PAGES];
      logic [31:0] pool_base;
      logic [10:0] pages_in_use;
      rsp_type     due_responses [$];
      // blocks granted so far, used to aim frees at real blocks
      logic [31:0] live_block_addr [$];
      int unsigned live_block_len [$];
      int unsigned mismatches;

      function new();
         foreach (marks[i]) marks[i] = MARK_NONE;
         pool_base    = '0;
         pages_in_use = '0;
         mismatches   = 0;
      endfunction

      function void write_register(logic index, logic [31:0] value);
         if (index == CSR_POOL_BASE) pool_base = value;
         else pages_in_use = value[10:0];
      endfunction

      function int unsigned pool_pages();
         return (pages_in_use > MAX_PAGES) ? MAX_PAGES : pages_in_use;
      endfunction

      function rsp_type allocate(int unsigned count);
         rsp_type     answer;
         int unsigned n;
         int unsigned run;
         int unsigned first;
         answer.status          = STATUS_NO_ROOM;
         answer.granted_address = '0;
         n   = pool_pages();
         run = 0;
         if (count == 0 || count > n) return answer;
         for (int unsigned i = 0; i < n; i++) begin
            if ((marks[i] & MARK_TAKEN) != MARK_NONE) begin
               run = 0;
            end else begin
               run++;
               if (run == count) begin
                  first = i + 1 - count;
                  for (int unsigned k = first; k <= i; k++) marks[k] |= MARK_TAKEN;
                  marks[i] |= MARK_LAST;
                  answer.status          = STATUS_OK;
                  answer.granted_address = pool_base + (32'(first) << PAGE_SHIFT);
                  live_block_addr.push_back(answer.granted_address);
                  live_block_len.push_back(count);
                  return answer;
               end
            end
         end
         return answer;
      endfunction

      function rsp_type free_block(logic [31:0] addr);
         rsp_type     answer;
         int unsigned n;
         int unsigned idx;
         logic [63:0] pool_end;
         logic        last;
         n        = pool_pages();
         pool_end = 64'(pool_base) + (64'(n) << PAGE_SHIFT);
         answer.granted_address = '0;
         if (addr == '0 || addr < pool_base || 64'(addr) >= pool_end) begin
            answer.status = STATUS_IGNORED;
            return answer;
         end
         answer.status = STATUS_OK;
         idx = (addr - pool_base) >> PAGE_SHIFT;
         while (idx < n && (marks[idx] & MARK_TAKEN) != MARK_NONE) begin
            last       = (marks[idx] & MARK_LAST) != MARK_NONE;
            marks[idx] = MARK_NONE;
            if (last) break;
            idx++;
         end
         for (int j = live_block_addr.size() - 1; j >= 0; j--) begin
            if (live_block_addr[j] == addr) begin
               live_block_addr.delete(j);
               live_block_len.delete(j);
            end
         end
         return answer;
      endfunction

      function void take_request(req_type r);
         if (r.op == OP_ALLOC) due_responses.push_back(allocate(r.page_count));
         else due_responses.push_back(free_block(r.block_address));
      endfunction

      function void grade_response(rsp_type got);
         rsp_type want;
         if (due_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with nothing owed: status %0d address %h",
                        got.status, got.granted_address);
            return;
         end
         want = due_responses.pop_front();
         if (got.status !== want.status || got.granted_address !== want.granted_address) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"response mismatch: expected status %0d address %h,",
                         " got status %0d address %h"},
                        want.status, want.granted_address, got.status, got.granted_address);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_index;
   logic [31:0] csr_data;

   page_pool_scoreboard sb = new();

   // idling on both sides for the current phase
   bit          idle_on;
   // cycles the sender holds off before offering its next request
   int unsigned next_gap;
   int unsigned quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   contiguous_page_allocator #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_SHIFT(PAGE_SHIFT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   // offer one request and hold it until the allocator takes it
   task automatic send_request(input req_type r);
      repeat (next_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.take_request(r);
      // draw the hold-off for the next request now, so valid only drops
      // when a gap really follows
      next_gap = idle_on ? $urandom_range(0, 10) : 0;
      if (next_gap > 0) req_valid <= 1'b0;
   endtask

   // make sure no accepted request stays offered while the sender waits
   task automatic pause_requests();
      if (next_gap == 0) begin
         req_valid <= 1'b0;
         next_gap = 1;
      end
   endtask

   task automatic wait_drained();
      pause_requests();
      while (sb.due_responses.size() != 0) @(posedge clock);
   endtask

   // both registers back to back, only with nothing in flight
   task automatic configure_pool(input logic [31:0] base_addr, input logic [10:0] pages);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= CSR_POOL_BASE;
      csr_data  <= base_addr;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(CSR_POOL_BASE, base_addr);
      csr_index <= CSR_PAGES_IN_USE;
      csr_data  <= {21'b0, pages};
      do @(posedge clock); while (!csr_ready);
      sb.write_register(CSR_PAGES_IN_USE, {21'b0, pages});
      csr_valid <= 1'b0;
      // blocks of an old setting would only aim frees at stale places
      sb.live_block_addr.delete();
      sb.live_block_len.delete();
   endtask

   task automatic alloc_pages(input int unsigned count);
      req_type r;
      r.op            = OP_ALLOC;
      r.page_count    = 11'(count);
      r.block_address = '0;
      send_request(r);
   endtask

   task automatic free_at(input logic [31:0] addr);
      req_type r;
      r.op            = OP_FREE;
      r.page_count    = '0;
      r.block_address = addr;
      send_request(r);
   endtask

   task automatic run_directed();
      // registers still at reset: empty pool
      alloc_pages(1);                  // no room at all
      free_at(32'h0000_1000);          // outside an empty pool

      configure_pool(32'h8000_0000, 11'd8);
      alloc_pages(0);                  // zero count
      alloc_pages(9);                  // one above the pool
      alloc_pages(11'h7ff);            // largest count the field holds
      alloc_pages(3);                  // pages 0..2
      alloc_pages(2);                  // pages 3..4
      free_at(32'h0000_0000);          // null free
      free_at(32'h7fff_ffff);          // just below the pool
      free_at(32'h8000_8000);          // exactly at the pool end
      free_at(32'h8000_3abc);          // unaligned, frees pages 3..4
      free_at(32'h8000_3000);          // page already free
      alloc_pages(3);                  // reuses the hole, pages 3..5
      free_at(32'h8000_1004);          // starts inside the first block
      alloc_pages(2);                  // refills pages 1..2
      free_at(32'h8000_7fff);          // last pool page, free

      // shrink: the block on pages 3..5 now sticks out of the pool
      configure_pool(32'h8000_0000, 11'd4);
      free_at(32'h8000_3000);          // walk stops at the pool end
      alloc_pages(1);

      // pool above the store, granted addresses wrap past 2^32
      configure_pool(32'hffff_e000, 11'h7ff);
      alloc_pages(8);                  // first fit past the hidden marks
      alloc_pages(MAX_PAGES);          // whole store, scans every page
      free_at(32'h0000_4000);          // wrapped grant lies below the base
      free_at(32'hffff_ffff);          // inside the pool above 2^32 - 1
      free_at(32'hffff_e000);

      // base 0: address 0 is a real page yet still ignored on free
      configure_pool(32'h0000_0000, 11'd4);
      free_at(32'h0000_0000);
      alloc_pages(1);                  // grants address 0
   endtask

   function automatic req_type next_random_request();
      req_type     r;
      int unsigned n;
      int unsigned roll;
      int unsigned k;
      int unsigned reach;
      n               = sb.pool_pages();
      r.op            = OP_ALLOC;
      r.page_count    = 11'($urandom);
      r.block_address = $urandom;
      roll            = $urandom_range(0, 99);
      if (roll < 45) begin
         // mostly counts that fit, now and then the edges or any value
         k = $urandom_range(0, 19);
         if (k == 0) r.page_count = '0;
         else if (k == 1) r.page_count = 11'(n);
         else if (k == 2) r.page_count = 11'(n + 1);
         else if (k > 3 && n > 0) begin
            reach        = (n > 12) ? n / 4 : n;
            r.page_count = 11'($urandom_range(1, reach));
         end
      end else if (roll < 88 && sb.live_block_addr.size() > 0) begin
         // free of a granted block, sometimes from inside or off the boundary
         r.op            = OP_FREE;
         k               = $urandom_range(0, sb.live_block_addr.size() - 1);
         r.block_address = sb.live_block_addr[k];
         if ($urandom_range(0, 3) == 0)
            r.block_address += 32'($urandom_range(0, sb.live_block_len[k] - 1)) << PAGE_SHIFT;
         if ($urandom_range(0, 3) == 0)
            r.block_address += 32'($urandom_range(0, 4095));
      end else begin
         // stray frees: null, edges of the pool, any page, any address
         r.op = OP_FREE;
         case ($urandom_range(0, 4))
            0: r.block_address = '0;
            1: r.block_address = sb.pool_base - 1;
            2: r.block_address = sb.pool_base + (32'(n) << PAGE_SHIFT);
            3: r.block_address = sb.pool_base + (32'($urandom_range(0, n)) << PAGE_SHIFT);
            default: ;
         endcase
      end
      return r;
   endfunction

   // response side: random stalls, held ready until a transaction completes
   initial begin
      int unsigned stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // grade responses and watch for a stuck handshake
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.grade_response(rsp_data);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("contiguous_page_allocator test failed");
         $finish;
      end
   end

   initial begin
      int unsigned total;
      int unsigned phase_items;
      int unsigned roll;
      logic [10:0] pages;
      logic [31:0] base_addr;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= CSR_POOL_BASE;
      csr_data     <= '0;
      idle_on  = 1'b1;
      next_gap = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // random phases, each with a fresh pool setting
      total = 0;
      while (total < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 9);
         case (roll)
            0: begin
               pages       = 11'($urandom_range(MAX_PAGES, 2047));
               phase_items = 15;
            end
            1: begin
               pages       = '0;
               phase_items = 8;
            end
            2: begin
               pages       = 11'($urandom_range(1, 2));
               phase_items = 30;
            end
            3: begin
               pages       = 11'($urandom_range(49, 300));
               phase_items = 20;
            end
            default: begin
               pages       = 11'($urandom_range(3, 48));
               phase_items = 50;
            end
         endcase
         base_addr = ($urandom_range(0, 3) == 0) ? $urandom : {20'($urandom), 12'h000};
         configure_pool(base_addr, pages);
         idle_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < phase_items; i++) begin
            // now and then the sender lets the allocator run dry
            if ($urandom_range(0, 59) == 0) wait_drained();
            send_request(next_random_request());
         end
         total += phase_items;
      end

      wait_drained();
      // room for any stray response after a full scan of the store
      repeat (2 * MAX_PAGES + 16) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_responses.size() == 0) begin
         $display("contiguous_page_allocator test passed");
      end else begin
         $display("contiguous_page_allocator test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/cpa_pkg.sv
rtl/cpa_ram.sv
rtl/cpa_ctrl.sv
rtl/cpa_dp.sv
rtl/contiguous_page_allocator.sv
rtl/cpa_checker.sv
test/tb_top.sv
